// ===== sv/wcenv_pkg.sv =====
// ----------------------------------------------------------------------------
// wcenv_pkg
// Shared types and constants for the waveform column envelope block.
// ----------------------------------------------------------------------------
package wcenv_pkg;

	localparam int SAMPLE_W      = 16;
	localparam int MASK_W        = 16;
	localparam int INDEX_W       = 16;
	localparam int LEN_W         = 16;
	localparam int ROW_COUNT_DEF = 16;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// register indexes, taken from paddr[2]
	localparam logic [0:0] REG_FORMAT = 1'b0;
	localparam logic [0:0] REG_WINDOW = 1'b1;

	// sample formats
	localparam logic FMT_S8  = 1'b0;
	localparam logic FMT_S16 = 1'b1;

	localparam logic             FORMAT_RST = FMT_S16;
	localparam logic [LEN_W-1:0] WINDOW_RST = 16'd1024;

	typedef struct packed {
		logic             sample_format;
		logic [LEN_W-1:0] window_len;
	} cfg_t;

endpackage

// ===== sv/wcenv_if.sv =====
// ----------------------------------------------------------------------------
// wcenv channels
// Valid/ready channels for input samples and output columns.
// ----------------------------------------------------------------------------
interface wcenv_sample_if
	import wcenv_pkg::*;
;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_value;
	logic                       last_sample;

	modport source (output valid, output sample_value, output last_sample, input ready);
	modport sink   (input valid, input sample_value, input last_sample, output ready);
endinterface

interface wcenv_column_if
	import wcenv_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [MASK_W-1:0]  column_mask;
	logic [INDEX_W-1:0] column_index;
	logic               column_last;

	modport source (output valid, output column_mask, output column_index,
		output column_last, input ready);
	modport sink   (input valid, input column_mask, input column_index,
		input column_last, output ready);
endinterface

// ===== sv/wcenv_cfg.sv =====
// ----------------------------------------------------------------------------
// wcenv_cfg
// APB-style register file: sample format and window length.
// ----------------------------------------------------------------------------
module wcenv_cfg
	import wcenv_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic             format_q;
	logic [LEN_W-1:0] window_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= FORMAT_RST;
			window_q <= WINDOW_RST;
		end else if (wr_en) begin
			case (paddr[2:2])
				REG_FORMAT: format_q <= pwdata[0];
				REG_WINDOW: window_q <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2:2])
			REG_FORMAT: prdata = {{(PDATA_W-1){1'b0}}, format_q};
			REG_WINDOW: prdata = {{(PDATA_W-LEN_W){1'b0}}, window_q};
			default:    prdata = '0;
		endcase
	end

	assign cfg.sample_format = format_q;
	assign cfg.window_len    = window_q;

endmodule

// ===== sv/wcenv_mask.sv =====
// ----------------------------------------------------------------------------
// wcenv_mask
// Scales window extremes to rows and builds the column mask.
// ----------------------------------------------------------------------------
module wcenv_mask
	import wcenv_pkg::*;
#(
	parameter int ROW_COUNT = ROW_COUNT_DEF
) (
	input  logic                       sample_format,
	input  logic signed [SAMPLE_W-1:0] win_min,
	input  logic signed [SAMPLE_W-1:0] win_max,
	output logic [MASK_W-1:0]          column_mask
);

	logic signed [SAMPLE_W+1:0] off_min;
	logic signed [SAMPLE_W+1:0] off_max;
	logic signed [SAMPLE_W+1:0] bias;

	assign bias    = (sample_format == FMT_S8) ? 18'sd128 : 18'sd32768;
	assign off_min = 18'(win_min) + bias;
	assign off_max = 18'(win_max) + bias;

	// scaled >= k  <=>  off >= ceil(k*range/ROW_COUNT); so row j is set when
	// max reaches threshold j+1 and min does not.
	for (genvar j = 0; j < ROW_COUNT; j++) begin : g_row
		localparam logic signed [SAMPLE_W+1:0] T8  =
			18'(((j + 1) * 255 + ROW_COUNT - 1) / ROW_COUNT);
		localparam logic signed [SAMPLE_W+1:0] T16 =
			18'(((j + 1) * 65535 + ROW_COUNT - 1) / ROW_COUNT);
		logic signed [SAMPLE_W+1:0] thr;
		assign thr = (sample_format == FMT_S8) ? T8 : T16;
		assign column_mask[j] = (off_max >= thr) && !(off_min >= thr);
	end

	for (genvar j = ROW_COUNT; j < MASK_W; j++) begin : g_unused
		assign column_mask[j] = 1'b0;
	end

endmodule

// ===== sv/wcenv_core.sv =====
// ----------------------------------------------------------------------------
// wcenv_core
// Input register, window min/max tracking and column output register.
// ----------------------------------------------------------------------------
module wcenv_core
	import wcenv_pkg::*;
#(
	parameter int ROW_COUNT = ROW_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	wcenv_sample_if.sink   samples,
	wcenv_column_if.source columns
);

	// input register
	logic                valid_s1;
	logic [SAMPLE_W-1:0] raw_s1;
	logic                last_s1;

	// window state
	logic signed [SAMPLE_W-1:0] wmin_q;
	logic signed [SAMPLE_W-1:0] wmax_q;
	logic [LEN_W-1:0]           wcount_q;
	logic [INDEX_W-1:0]         colidx_q;

	// output register
	logic               valid_s2;
	logic [MASK_W-1:0]  mask_s2;
	logic [INDEX_W-1:0] index_s2;
	logic               last_s2;

	logic signed [SAMPLE_W-1:0] v;
	logic signed [SAMPLE_W-1:0] new_min;
	logic signed [SAMPLE_W-1:0] new_max;
	logic [LEN_W-1:0]           cnt_next;
	logic                       close;
	logic                       out_free;
	logic                       adv;
	logic                       take;
	logic [MASK_W-1:0]          mask;

	assign v = (cfg.sample_format == FMT_S8) ?
		$signed({{(SAMPLE_W-8){raw_s1[7]}}, raw_s1[7:0]}) : $signed(raw_s1);
	assign new_min  = (v < wmin_q) ? v : wmin_q;
	assign new_max  = (v > wmax_q) ? v : wmax_q;
	assign cnt_next = wcount_q + 1'b1;
	assign close    = last_s1 || (cnt_next >= cfg.window_len);

	// a sample that closes no column never waits on the output side
	assign out_free = !valid_s2 || columns.ready;
	assign adv      = valid_s1 && (!close || out_free);
	assign samples.ready = !valid_s1 || adv;
	assign take     = samples.valid && samples.ready;

	wcenv_mask #(.ROW_COUNT(ROW_COUNT)) u_mask (
		.sample_format (cfg.sample_format),
		.win_min       (new_min),
		.win_max       (new_max),
		.column_mask   (mask)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			raw_s1  <= samples.sample_value;
			last_s1 <= samples.last_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wmin_q   <= 16'sh7FFF;
			wmax_q   <= 16'sh8000;
			wcount_q <= '0;
			colidx_q <= '0;
		end else if (adv) begin
			if (close) begin
				wmin_q   <= 16'sh7FFF;
				wmax_q   <= 16'sh8000;
				wcount_q <= '0;
				colidx_q <= last_s1 ? '0 : colidx_q + 1'b1;
			end else begin
				wmin_q   <= new_min;
				wmax_q   <= new_max;
				wcount_q <= cnt_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv && close) begin
			valid_s2 <= 1'b1;
		end else if (columns.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && close) begin
			mask_s2  <= mask;
			index_s2 <= colidx_q;
			last_s2  <= last_s1;
		end
	end

	assign columns.valid        = valid_s2;
	assign columns.column_mask  = mask_s2;
	assign columns.column_index = index_s2;
	assign columns.column_last  = last_s2;

endmodule

// ===== sv/waveform_column_envelope.sv =====
// ----------------------------------------------------------------------------
// waveform_column_envelope
// Min/max envelope of a mono sample stream, one row mask per column.
// ----------------------------------------------------------------------------
// Samples arrive on the samples channel, one transfer per sample, with
// last_sample marking the end of a clip. Every window_len samples, or at the
// end of a clip, one column transfer leaves on the columns channel: a row
// mask covering the scaled min..max range, the column index, and a last flag.
// Format and window length are set through the APB port; the user must write them
// only while the block is idle, which the block does not enforce; pready is always high.
// Throughput: one sample per cycle, set by the single min/max update stage,
// unless a closing sample waits on a stalled receiver. Each closing sample
// passes the input register, then its column the column output register.
// Reset clears the window, the column counter and both valid flags; the
// registers return to 16-bit format and a window of 1024 samples.
// When the receiver stalls, the finished column holds in the output register;
// samples that close no column keep flowing, and a sample that would close
// the next column waits in the input register with ready low.
// ----------------------------------------------------------------------------
module waveform_column_envelope
	import wcenv_pkg::*;
#(
	parameter int ROW_COUNT = ROW_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	wcenv_sample_if.sink       samples,
	wcenv_column_if.source     columns
);

	cfg_t cfg;

	wcenv_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wcenv_core #(.ROW_COUNT(ROW_COUNT)) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.samples (samples),
		.columns (columns)
	);

endmodule

// ===== tb/waveform_column_envelope_test.sv =====
// ----------------------------------------------------------------------------
// waveform_column_envelope_test
// Self-checking test of the min/max column envelope block.
// ----------------------------------------------------------------------------
// A local envelope tracker follows every accepted sample and queues the
// column it should close. The checker compares each column transfer with
// the oldest queued column. Directed tests cover full-scale samples, byte
// samples, zero and maximum window lengths, and window length or format
// changes in the middle of a window. Random clips with random register
// settings follow. A long receiver hold-off fills the block. Both sides
// idle at random except in the final part of the run.
// ----------------------------------------------------------------------------
module waveform_column_envelope_test;
	import wcenv_pkg::*;

	localparam int STALL_LIMIT  = 1000;
	localparam int MAX_REPORTS  = 10;
	localparam int DRAIN_CYCLES = 4;
	localparam int HOLD_CYCLES  = 80;

	typedef struct packed {
		logic [MASK_W-1:0]  mask;
		logic [INDEX_W-1:0] index;
		logic               last;
	} column_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	wcenv_sample_if samples_ch ();
	wcenv_column_if columns_ch ();

	waveform_column_envelope dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.samples (samples_ch),
		.columns (columns_ch)
	);

	// envelope tracker state and its copy of the registers
	logic               env_format;
	logic [LEN_W-1:0]   env_window_len;
	logic [LEN_W-1:0]   env_count;
	logic [INDEX_W-1:0] env_column;
	int                 env_min;
	int                 env_max;

	column_t     pending_columns[$];
	int          errors;
	int          samples_sent;
	int          columns_seen;
	int          config_writes;
	int          idle_cycles;
	bit          sender_idle;
	bit          receiver_idle;
	int unsigned hold_off_req;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void report_mismatch(string what, longint unsigned want_val,
		longint unsigned got_val);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("  %s: expected %0h, got %0h", what, want_val, got_val);
	endfunction

	function automatic int scale_to_rows(int v, logic fmt);
		int offset;
		int span;
		int rows;
		if (fmt == FMT_S8) begin
			offset = v + 128;
			span   = 255;
		end else begin
			offset = v + 32768;
			span   = 65535;
		end
		if (offset < 0)
			return 0;
		rows = offset * ROW_COUNT_DEF / span;
		return (rows > ROW_COUNT_DEF) ? ROW_COUNT_DEF : rows;
	endfunction

	// update window extremes; queue a column when the window closes
	function automatic void track_envelope(logic [SAMPLE_W-1:0] raw, logic last);
		int      v;
		int      row_lo;
		int      row_hi;
		int      j;
		column_t col;
		if (env_format == FMT_S8)
			v = int'($signed(raw[7:0]));
		else
			v = int'($signed(raw));
		if (v < env_min)
			env_min = v;
		if (v > env_max)
			env_max = v;
		env_count = env_count + 1'b1;
		if (!last && env_count < env_window_len)
			return;
		row_lo   = scale_to_rows(env_min, env_format);
		row_hi   = scale_to_rows(env_max, env_format);
		col.mask = '0;
		for (j = 0; j < ROW_COUNT_DEF; j++)
			if (j >= row_lo && j < row_hi)
				col.mask[j] = 1'b1;
		col.index = env_column;
		col.last  = last;
		pending_columns.push_back(col);
		env_min    = 32767;
		env_max    = -32768;
		env_count  = '0;
		env_column = last ? '0 : env_column + 1'b1;
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return {8'($urandom), 8'h80};
			3: return {8'($urandom), 8'h7F};
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_sample(logic [SAMPLE_W-1:0] raw, logic last);
		if (sender_idle && $urandom_range(0, 3) == 0) begin
			samples_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		samples_ch.valid        <= 1'b1;
		samples_ch.sample_value <= raw;
		samples_ch.last_sample  <= last;
		do @(posedge clk); while (!samples_ch.ready);
		track_envelope(raw, last);
		samples_sent++;
	endtask

	// block idle: no column owed, and any sample still in the pipeline has settled
	task automatic wait_idle();
		samples_ch.valid <= 1'b0;
		while (pending_columns.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [0:0] reg_idx, logic [LEN_W-1:0] value);
		logic [PDATA_W-1:0] used_bits;
		wait_idle();
		used_bits = (reg_idx == REG_FORMAT) ? 32'h1 : 32'hFFFF;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// read back straight after the write
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if ((prdata & used_bits) !== (PDATA_W'(value) & used_bits))
			report_mismatch($sformatf("register %0d readback", reg_idx),
				64'(PDATA_W'(value) & used_bits), 64'(prdata & used_bits));
		psel    <= 1'b0;
		penable <= 1'b0;
		if (reg_idx == REG_FORMAT)
			env_format = value[0];
		else
			env_window_len = value;
		config_writes++;
	endtask

	task automatic test_full_scale_words();
		// reset settings: 16-bit samples, 1024-sample window
		send_sample(16'h8000, 1'b0);
		send_sample(16'h7FFF, 1'b1);
		send_sample(16'h0000, 1'b1);
	endtask

	task automatic test_byte_samples();
		write_register(REG_FORMAT, LEN_W'(FMT_S8));
		write_register(REG_WINDOW, 16'd3);
		// only the low byte counts
		send_sample(16'h7F80, 1'b0);
		send_sample(16'h807F, 1'b0);
		send_sample(16'h0000, 1'b0);
		send_sample(16'hFFC0, 1'b0);
		send_sample(16'h0040, 1'b1);
		// zero length closes on every sample
		write_register(REG_WINDOW, 16'd0);
		send_sample(16'h0055, 1'b0);
		send_sample(16'hAAAA, 1'b0);
	endtask

	task automatic test_window_shrink();
		write_register(REG_FORMAT, LEN_W'(FMT_S16));
		write_register(REG_WINDOW, 16'd10);
		send_sample(16'hF000, 1'b0);
		send_sample(16'h1000, 1'b0);
		send_sample(16'h3000, 1'b0);
		send_sample(16'hC000, 1'b0);
		send_sample(16'h0000, 1'b0);
		// count already past the new length: next sample closes
		write_register(REG_WINDOW, 16'd3);
		send_sample(16'h2000, 1'b0);
	endtask

	task automatic test_format_switch();
		write_register(REG_WINDOW, 16'd100);
		send_sample(16'hB1E0, 1'b0);
		send_sample(16'h4E20, 1'b0);
		// word extremes scaled as bytes: clamped at both ends
		write_register(REG_FORMAT, LEN_W'(FMT_S8));
		send_sample(16'h0000, 1'b1);
		send_sample(16'h0080, 1'b0);
		write_register(REG_FORMAT, LEN_W'(FMT_S16));
		send_sample(16'h007F, 1'b1);
	endtask

	task automatic test_longest_window();
		write_register(REG_WINDOW, 16'hFFFF);
		send_sample(16'h8000, 1'b0);
		send_sample(16'h4000, 1'b0);
		send_sample(16'h7FFF, 1'b1);
	endtask

	task automatic test_random_clips();
		int phase;
		logic [LEN_W-1:0] len;
		for (phase = 0; phase < 12; phase++) begin
			case ($urandom_range(0, 9))
				0: len = 16'd0;
				1: len = 16'hFFFF;
				2: len = 16'd1;
				default: len = LEN_W'($urandom_range(2, 12));
			endcase
			write_register(REG_FORMAT, LEN_W'($urandom_range(0, 1)));
			write_register(REG_WINDOW, len);
			sender_idle   = $urandom_range(0, 2) != 0;
			receiver_idle = $urandom_range(0, 2) != 0;
			repeat (32)
				send_sample(pick_sample(), $urandom_range(0, 15) == 0);
		end
	endtask

	task automatic test_output_backpressure();
		write_register(REG_FORMAT, LEN_W'($urandom_range(0, 1)));
		write_register(REG_WINDOW, 16'd1);
		sender_idle   = 1'b0;
		receiver_idle = 1'b0;
		hold_off_req  = HOLD_CYCLES;
		repeat (40)
			send_sample(pick_sample(), $urandom_range(0, 9) == 0);
	endtask

	// column receiver: random stall bursts plus a requested long hold-off
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		columns_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req != 0) begin
				stall_left   = hold_off_req;
				hold_off_req = 0;
			end else if (stall_left == 0 && receiver_idle && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 14);
			end
			if (stall_left != 0) begin
				columns_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				columns_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		column_t want;
		if (arst_n && columns_ch.valid && columns_ch.ready) begin
			columns_seen++;
			if (pending_columns.size() == 0) begin
				report_mismatch("column with none owed, index", 64'd0,
					64'(columns_ch.column_index));
			end else begin
				want = pending_columns.pop_front();
				if (columns_ch.column_mask !== want.mask)
					report_mismatch($sformatf("column %0d mask", want.index),
						64'(want.mask), 64'(columns_ch.column_mask));
				if (columns_ch.column_index !== want.index)
					report_mismatch("column index", 64'(want.index),
						64'(columns_ch.column_index));
				if (columns_ch.column_last !== want.last)
					report_mismatch($sformatf("column %0d last", want.index),
						64'(want.last), 64'(columns_ch.column_last));
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((samples_ch.valid && samples_ch.ready) || (columns_ch.valid && columns_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
				$display("waveform_column_envelope: mismatch");
				$finish;
			end
		end
	end

	initial begin
		arst_n                  <= 1'b0;
		psel                    <= 1'b0;
		penable                 <= 1'b0;
		pwrite                  <= 1'b0;
		paddr                   <= '0;
		pwdata                  <= '0;
		samples_ch.valid        <= 1'b0;
		samples_ch.sample_value <= '0;
		samples_ch.last_sample  <= 1'b0;
		env_format     = FORMAT_RST;
		env_window_len = WINDOW_RST;
		env_count      = '0;
		env_column     = '0;
		env_min        = 32767;
		env_max        = -32768;
		errors         = 0;
		samples_sent   = 0;
		columns_seen   = 0;
		config_writes  = 0;
		idle_cycles    = 0;
		hold_off_req   = 0;
		sender_idle    = 1'b1;
		receiver_idle  = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_full_scale_words();
		test_byte_samples();
		test_window_shrink();
		test_format_switch();
		test_longest_window();
		test_random_clips();
		test_output_backpressure();

		wait_idle();
		repeat (8) @(posedge clk);
		$display("%0d samples, %0d columns checked, %0d register writes",
			samples_sent, columns_seen, config_writes);
		$display("both formats, windows 0 to 65535, mid-window changes and a long output stall");
		if (errors == 0 && pending_columns.size() == 0)
			$display("waveform_column_envelope: match");
		else
			$display("waveform_column_envelope: mismatch");
		$finish;
	end

endmodule
